// ===== sv/hmth_pkg.sv =====
// Shared types and constants for the heightmap triangle height query block.
// No dependencies; imported by hmth_front, hmth_back and the top level.
package hmth_pkg;

   // request modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // register select (word index taken from the byte address)
   localparam logic REG_GRID_DIM     = 1'b0;
   localparam logic REG_HEIGHT_SCALE = 1'b1;

   localparam int          DIM_W        = 9;
   localparam int          SCALE_W      = 24;
   localparam logic [8:0]  DIM_RESET    = 9'd256;
   localparam logic [8:0]  DIM_MIN      = 9'd2;
   localparam logic [23:0] SCALE_RESET  = 24'd256;

   // divide by 255: floor(2^32/255) and the divisor
   localparam logic [24:0] RECIP_255    = 25'd16843009;
   localparam logic [32:0] DIVISOR_255  = 33'd255;

   // configuration as seen by the datapath (dimension already clamped)
   typedef struct packed {
      logic [DIM_W-1:0]   dim;
      logic [SCALE_W-1:0] scale;
   } hmth_cfg_type;

   // back-end sequencer states
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MAC,
      BK_MUL,
      BK_RCP,
      BK_FIX
   } hmth_bk_state_type;

   // packed width of one queue entry:
   // is_load, in_range, lower, index, data, three weights
   function automatic int hmth_entry_width(input int aw, input int frac_bits);
      return 3 + aw + 8 + 3 * (frac_bits + 1);
   endfunction

endpackage

// ===== sv/hmth_queue.sv =====
// Small register FIFO between the front and the back of the block.
// Depends on nothing; width and depth come from parameters.
module hmth_queue #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff,  count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== sv/hmth_front.sv =====
// Front end: accepts requests, range-checks queries, forms the cell base index
// and triangle weights, and pushes one entry per useful request. Uses hmth_pkg.
module hmth_front #(
   parameter int GRID_MAX  = 256,
   parameter int FRAC_BITS = 8,
   localparam int AW = $clog2(GRID_MAX * GRID_MAX),
   localparam int EW = hmth_pkg::hmth_entry_width(AW, FRAC_BITS)
) (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode,
   input  logic [15:0]           req_load_index,
   input  logic [7:0]            req_height_byte,
   input  logic signed [23:0]    req_pos_x,
   input  logic signed [23:0]    req_pos_z,
   input  hmth_pkg::hmth_cfg_type cfg,
   output logic                  q_push,
   output logic [EW-1:0]         q_wdata,
   input  logic                  q_full
);

   import hmth_pkg::*;

   localparam int          WW         = FRAC_BITS + 1;
   localparam int          XW         = 23 - FRAC_BITS;
   localparam int          CW         = ((XW > DIM_W) ? XW : DIM_W) + 1;
   localparam int          MW         = XW + DIM_W;
   localparam logic [31:0] STORE_SIZE = 32'(GRID_MAX * GRID_MAX);

   typedef struct packed {
      logic          is_load;
      logic          in_range;
      logic          lower;
      logic [AW-1:0] index;
      logic [7:0]    data;
      logic [WW-1:0] wa;
      logic [WW-1:0] wb;
      logic [WW-1:0] wc;
   } entry_type;

   entry_type            entry;
   logic [XW-1:0]        xi, zi;
   logic [FRAC_BITS-1:0] u, v, diff, w_b, w_c;
   logic [CW-1:0]        lim;
   logic                 negative, in_range, lower, in_store;
   logic [MW-1:0]        base_idx;

   assign xi       = req_pos_x[22:FRAC_BITS];
   assign zi       = req_pos_z[22:FRAC_BITS];
   assign u        = req_pos_x[FRAC_BITS-1:0];
   assign v        = req_pos_z[FRAC_BITS-1:0];
   assign negative = req_pos_x[23] || req_pos_z[23];

   // cell must have a right and an upper neighbor
   assign lim      = CW'(cfg.dim) - CW'(1);
   assign in_range = !negative && (CW'(xi) < lim) && (CW'(zi) < lim);

   assign base_idx = MW'(zi) * MW'(cfg.dim) + MW'(xi);

   assign lower = (u > v);
   assign diff  = lower ? (u - v) : (v - u);
   assign w_b   = lower ? v : u;
   assign w_c   = lower ? u : v;

   assign in_store = (32'(req_load_index) < STORE_SIZE);

   always_comb begin
      entry.is_load  = (req_mode == MODE_LOAD);
      entry.in_range = in_range;
      entry.lower    = lower;
      entry.index    = (req_mode == MODE_LOAD) ? AW'(req_load_index) : AW'(base_idx);
      entry.data     = req_height_byte;
      entry.wa       = {1'b0, diff};
      entry.wb       = {1'b0, w_b};
      entry.wc       = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, w_c};
   end

   assign req_stall = q_full;
   assign q_wdata   = entry;
   // loads past the end of the store are dropped here
   assign q_push    = req_valid && !q_full && ((req_mode == MODE_QUERY) || in_store);

endmodule

// ===== sv/hmth_back.sv =====
// Back end: owns the height store, performs loads, and runs queries through
// a three-read multiply-accumulate, a scale multiply and a divide by 255*2^F.
// Uses hmth_pkg.
module hmth_back #(
   parameter int GRID_MAX  = 256,
   parameter int FRAC_BITS = 8,
   localparam int AW = $clog2(GRID_MAX * GRID_MAX),
   localparam int EW = hmth_pkg::hmth_entry_width(AW, FRAC_BITS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hmth_pkg::hmth_cfg_type cfg,
   input  logic                   q_empty,
   input  logic [EW-1:0]          q_rdata,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [24:0]            rsp_height_out,
   output logic                   rsp_in_range
);

   import hmth_pkg::*;

   localparam int STORE_SIZE = GRID_MAX * GRID_MAX;
   localparam int WW         = FRAC_BITS + 1;
   localparam int HW         = 8 + FRAC_BITS;
   localparam int PRW        = HW + SCALE_W;

   typedef struct packed {
      logic          is_load;
      logic          in_range;
      logic          lower;
      logic [AW-1:0] index;
      logic [7:0]    data;
      logic [WW-1:0] wa;
      logic [WW-1:0] wb;
      logic [WW-1:0] wc;
   } entry_type;

   entry_type         head;
   entry_type         job_ff, job_in;
   hmth_bk_state_type state_ff, state_in;
   logic [1:0]        step_ff, step_in;
   logic [7:0]        store_mem [STORE_SIZE];
   logic [7:0]        rd_data_ff;
   logic [AW-1:0]     rd_addr, rd_off;
   logic              wr_en;
   logic [HW-1:0]     acc_ff, acc_in;
   logic [WW-1:0]     w_sel;
   logic [HW:0]       mac_sum;
   logic [PRW-1:0]    prod_ff, prod_in;
   logic [31:0]       n_ff, n_in;
   logic [56:0]       recip_prod;
   logic [24:0]       qe_ff, qe_in, q_fix;
   logic [32:0]       rem;
   logic              out_free;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [24:0]       rsp_height_ff, rsp_height_in;
   logic              rsp_in_range_ff, rsp_in_range_in;

   assign head = q_rdata;

   // corner offsets from the lower-left sample
   always_comb begin
      case (step_ff)
         2'd0:    rd_off = job_ff.lower ? AW'(1) : AW'(cfg.dim);
         2'd1:    rd_off = AW'(cfg.dim) + AW'(1);
         default: rd_off = '0;
      endcase
   end
   assign rd_addr = job_ff.index + rd_off;

   // weight of the byte that arrives this cycle (read issued one step back)
   always_comb begin
      case (step_ff)
         2'd1:    w_sel = job_ff.wa;
         2'd2:    w_sel = job_ff.wb;
         default: w_sel = job_ff.wc;
      endcase
   end
   assign mac_sum = (HW+1)'(acc_ff) + (HW+1)'(rd_data_ff) * (HW+1)'(w_sel);

   assign recip_prod = 57'(prod_ff[FRAC_BITS +: 32]) * 57'(RECIP_255);
   assign rem        = 33'(n_ff) - 33'(qe_ff) * DIVISOR_255;
   assign q_fix      = (rem >= DIVISOR_255) ? qe_ff + 25'd1 : qe_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in        = state_ff;
      job_in          = job_ff;
      step_in         = step_ff;
      acc_in          = acc_ff;
      prod_in         = prod_ff;
      n_in            = n_ff;
      qe_in           = qe_ff;
      q_pop           = 1'b0;
      wr_en           = 1'b0;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_height_in   = rsp_height_ff;
      rsp_in_range_in = rsp_in_range_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (head.is_load) begin
                  wr_en = 1'b1;
               end else begin
                  job_in   = head;
                  step_in  = 2'd0;
                  acc_in   = '0;
                  state_in = head.in_range ? BK_MAC : BK_FIX;
               end
            end
         end
         BK_MAC: begin
            if (step_ff != 2'd0) begin
               acc_in = HW'(mac_sum);
            end
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            prod_in  = PRW'(acc_ff) * PRW'(cfg.scale);
            state_in = BK_RCP;
         end
         BK_RCP: begin
            n_in     = prod_ff[FRAC_BITS +: 32];
            qe_in    = recip_prod[56:32];
            state_in = BK_FIX;
         end
         BK_FIX: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_height_in   = job_ff.in_range ? q_fix : '0;
               rsp_in_range_in = job_ff.in_range;
               state_in        = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         step_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff          <= job_in;
      acc_ff          <= acc_in;
      prod_ff         <= prod_in;
      n_ff            <= n_in;
      qe_ff           <= qe_in;
      rsp_height_ff   <= rsp_height_in;
      rsp_in_range_ff <= rsp_in_range_in;
   end

   // height store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[head.index] <= head.data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_height_out = rsp_height_ff;
   assign rsp_in_range   = rsp_in_range_ff;

endmodule

// ===== sv/heightmap_triangle_height_query.sv =====
// Top level of the heightmap triangle height query block: register port,
// front end, request queue and back end. Uses hmth_pkg, hmth_front,
// hmth_queue and hmth_back.
//
//   channel   direction   handshake              contents
//   req_*     in          req_valid / req_stall  mode, load index, byte, x, z
//   rsp_*     out         rsp_valid / rsp_stall  height_out, in_range
//   csr_*     in/out      APB setup + access     grid_dim @0x0, height_scale @0x4
//
// Loads retire one per cycle from the queue while the back end is idle.
// A query is popped and runs alone through the multiply-accumulate (the
// single read port of the height store serves the three corners one after
// another), then scale, reciprocal and correction, which waits while the
// result register is busy; a query outside the grid skips to correction.
// Reset clears control state and sets grid_dim = 256, height_scale = 256;
// the height store is not cleared and holds garbage until loaded.
// The 4-entry queue lets requests keep coming while the back end works or
// a result waits on rsp_stall; req_stall rises only when the queue is full.
module heightmap_triangle_height_query #(
   parameter int GRID_MAX  = 256,
   parameter int FRAC_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_mode,
   input  logic [15:0]          req_load_index,
   input  logic [7:0]           req_height_byte,
   input  logic signed [23:0]   req_pos_x,
   input  logic signed [23:0]   req_pos_z,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [24:0]          rsp_height_out,
   output logic                 rsp_in_range,
   // register port
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   import hmth_pkg::*;

   localparam int AW     = $clog2(GRID_MAX * GRID_MAX);
   localparam int EW     = hmth_entry_width(AW, FRAC_BITS);
   localparam int QDEPTH = 4;

   logic [DIM_W-1:0]   grid_dim_ff,     grid_dim_in;
   logic [SCALE_W-1:0] height_scale_ff, height_scale_in;
   logic               reg_sel;
   logic               csr_write;
   hmth_cfg_type       cfg;
   logic               q_push, q_pop, q_full, q_empty;
   logic [EW-1:0]      q_wdata, q_rdata;

   // ------------------------------------------------------------------
   // Register port. Word select is address bit 2; pready is tied high.
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      grid_dim_in     = grid_dim_ff;
      height_scale_in = height_scale_ff;
      if (csr_write) begin
         case (reg_sel)
            REG_GRID_DIM:     grid_dim_in     = csr_pwdata[DIM_W-1:0];
            REG_HEIGHT_SCALE: height_scale_in = csr_pwdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_dim_ff     <= DIM_RESET;
         height_scale_ff <= SCALE_RESET;
      end else begin
         grid_dim_ff     <= grid_dim_in;
         height_scale_ff <= height_scale_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_GRID_DIM:     csr_prdata = 32'(grid_dim_ff);
         REG_HEIGHT_SCALE: csr_prdata = 32'(height_scale_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Effective grid size, clamped to [2, GRID_MAX]. Always fits 9 bits
   // since grid_dim itself does.
   always_comb begin
      cfg.scale = height_scale_ff;
      if (grid_dim_ff < DIM_MIN) begin
         cfg.dim = DIM_MIN;
      end else if (32'(grid_dim_ff) > 32'(GRID_MAX)) begin
         cfg.dim = DIM_W'(GRID_MAX);
      end else begin
         cfg.dim = grid_dim_ff;
      end
   end

   // ------------------------------------------------------------------
   // Front end: classify and range-check, build queue entries.
   // ------------------------------------------------------------------
   hmth_front #(
      .GRID_MAX  (GRID_MAX),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_load_index  (req_load_index),
      .req_height_byte (req_height_byte),
      .req_pos_x       (req_pos_x),
      .req_pos_z       (req_pos_z),
      .cfg             (cfg),
      .q_push          (q_push),
      .q_wdata         (q_wdata),
      .q_full          (q_full)
   );

   // ------------------------------------------------------------------
   // Queue: keeps loads and queries in request order.
   // ------------------------------------------------------------------
   hmth_queue #(
      .DEPTH (QDEPTH),
      .WIDTH (EW)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   // ------------------------------------------------------------------
   // Back end: height store, interpolation, scaling, result register.
   // ------------------------------------------------------------------
   hmth_back #(
      .GRID_MAX  (GRID_MAX),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .q_empty        (q_empty),
      .q_rdata        (q_rdata),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_height_out (rsp_height_out),
      .rsp_in_range   (rsp_in_range)
   );

endmodule

// ===== tb/sv/heightmap_triangle_height_query_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for heightmap_triangle_height_query: random and directed
// loads/queries, APB register writes, shadow height store and scoreboard class.
// Depends on hmth_pkg and the heightmap_triangle_height_query RTL.
module heightmap_triangle_height_query_tb;
   import hmth_pkg::*;

   localparam int STORE_DEPTH   = 65536;
   localparam int ONE           = 256;      // 1.0 at 8 fractional bits
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 64;       // idle wait after the last result, with margin
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SEG_ITEMS     = 155;

   typedef struct packed {
      logic [24:0] height;
      logic        in_range;
   } height_rsp_type;

   // Shadow of the height store and registers, plus the queue of expected heights.
   class heightmap_mirror;
      logic [7:0]     heights [STORE_DEPTH];
      bit             written [STORE_DEPTH];
      logic [8:0]     grid_dim;
      logic [23:0]    height_scale;
      height_rsp_type pending [$];
      int             errors;
      int             loads;
      int             queries;
      int             hits;

      function new();
         grid_dim     = DIM_RESET;
         height_scale = SCALE_RESET;
         errors  = 0;
         loads   = 0;
         queries = 0;
         hits    = 0;
      endfunction

      // grid_dim clamped to [2, 256]
      function int unsigned dim_used();
         if (grid_dim < 2) return 2;
         if (grid_dim > 256) return 256;
         return grid_dim;
      endfunction

      function bit cell_ready(int unsigned xi, int unsigned zi);
         int unsigned d;
         int unsigned bl;
         d  = dim_used();
         bl = xi + zi * d;
         return written[bl] && written[bl + 1] && written[bl + d] && written[bl + d + 1];
      endfunction

      function void write_reg(logic sel, logic [31:0] value);
         if (sel == REG_GRID_DIM) grid_dim = value[8:0];
         else height_scale = value[23:0];
      endfunction

      // barycentric blend of the three corners, then scale by height_scale/255
      function height_rsp_type interp_height(logic signed [23:0] x, logic signed [23:0] z);
         height_rsp_type  res;
         int unsigned     d;
         int unsigned     xi;
         int unsigned     zi;
         int unsigned     u;
         int unsigned     v;
         int unsigned     bl;
         int unsigned     tl;
         longint unsigned acc;
         res = '0;
         if (x < 0 || z < 0) return res;
         d  = dim_used();
         xi = x[23:8];
         zi = z[23:8];
         if (xi + 1 >= d || zi + 1 >= d) return res;
         u  = x[7:0];
         v  = z[7:0];
         bl = xi + zi * d;
         tl = bl + d;
         if (u > v)   // lower-right triangle: br, tr, bl
            acc = heights[bl + 1] * (u - v) + heights[tl + 1] * v + heights[bl] * (ONE - u);
         else         // upper-left triangle: tl, tr, bl
            acc = heights[tl] * (v - u) + heights[tl + 1] * u + heights[bl] * (ONE - v);
         acc = (acc * height_scale) / (255 * ONE);
         res.height   = acc[24:0];
         res.in_range = 1'b1;
         return res;
      endfunction

      function void note_request(logic mode, logic [15:0] idx, logic [7:0] hb,
                                 logic signed [23:0] x, logic signed [23:0] z);
         height_rsp_type res;
         if (mode == MODE_LOAD) begin
            heights[idx] = hb;
            written[idx] = 1'b1;
            loads++;
         end else begin
            res = interp_height(x, z);
            if (res.in_range) hits++;
            pending.insert(pending.size(), res);
            queries++;
         end
      endfunction

      function void check_result(logic [24:0] h, logic r);
         height_rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, height_out %0d in_range %0d", $time, h, r);
            return;
         end
         want = pending.pop_front();
         if (h !== want.height) begin
            errors++;
            $display("%0t: height_out expected %0d, got %0d", $time, want.height, h);
         end
         if (r !== want.in_range) begin
            errors++;
            $display("%0t: in_range expected %0d, got %0d", $time, want.in_range, r);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_mode = MODE_LOAD;
   logic [15:0]        req_load_index = '0;
   logic [7:0]         req_height_byte = '0;
   logic signed [23:0] req_pos_x = '0;
   logic signed [23:0] req_pos_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [24:0]        rsp_height_out;
   logic               rsp_in_range;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   heightmap_mirror mirror;
   int          send_idle_pct = 0;   // chance per cycle that the sender holds off
   int          recv_idle_pct = 0;   // chance per cycle that the receiver stalls
   int          items_sent    = 0;
   int          csr_writes    = 0;
   int          cycle_count   = 0;
   int unsigned cells [$];           // loaded cells under the current dim, {zi, xi}

   heightmap_triangle_height_query u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_load_index  (req_load_index),
      .req_height_byte (req_height_byte),
      .req_pos_x       (req_pos_x),
      .req_pos_z       (req_pos_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_height_out  (rsp_height_out),
      .rsp_in_range    (rsp_in_range),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #2 clock = ~clock;

   // Result side: check on every accepted result, stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         mirror.check_result(rsp_height_out, rsp_in_range);
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Watchdog: a hang or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, CYCLE_LIMIT, mirror.pending.size());
         $display("heightmap_triangle_height_query_tb: done, errors");
         $finish;
      end
   end

   // Byte with a bias toward the extremes.
   function automatic logic [7:0] rand_height();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] rand_frac();
      case ($urandom_range(0, 5))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   // One request; returns at the edge that accepts it. Valid stays up so a
   // following request can go back to back.
   task automatic send_request(logic mode, logic [15:0] idx, logic [7:0] hb,
                               logic signed [23:0] x, logic signed [23:0] z);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_load_index  <= idx;
      req_height_byte <= hb;
      req_pos_x       <= x;
      req_pos_z       <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mirror.note_request(mode, idx, hb, x, z);
      items_sent++;
   endtask

   // Unused fields carry noise: the block must ignore them.
   task automatic send_load(logic [15:0] idx, logic [7:0] hb);
      send_request(MODE_LOAD, idx, hb, 24'($urandom), 24'($urandom));
   endtask

   task automatic send_query(logic signed [23:0] x, logic signed [23:0] z);
      send_request(MODE_QUERY, 16'($urandom), 8'($urandom), x, z);
   endtask

   // Write the four corners of a cell, or only those not yet written.
   task automatic load_cell(int unsigned xi, int unsigned zi, bit only_missing);
      int unsigned d;
      int unsigned bl;
      int unsigned corner [4];
      d  = mirror.dim_used();
      bl = xi + zi * d;
      corner = '{bl, bl + 1, bl + d, bl + d + 1};
      foreach (corner[k])
         if (!only_missing || !mirror.written[corner[k]])
            send_load(16'(corner[k]), rand_height());
   endtask

   // Random point in a cell; u == v (the triangle diagonal) now and then.
   task automatic query_cell(int unsigned xi, int unsigned zi);
      logic [7:0] u;
      logic [7:0] v;
      u = rand_frac();
      v = ($urandom_range(0, 4) == 0) ? u : rand_frac();
      send_query(24'(xi * ONE + u), 24'(zi * ONE + v));
   endtask

   // Stop requests, wait for every result, then let queued loads retire.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mirror.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup, access, done when pready is seen with penable.
   task automatic csr_write(logic sel, logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      mirror.write_reg(sel, value);
      csr_writes++;
   endtask

   task automatic configure(logic [8:0] dim, logic [23:0] scale);
      settle();
      csr_write(REG_GRID_DIM, 32'(dim));
      csr_write(REG_HEIGHT_SCALE, 32'(scale));
      cells.delete();
   endtask

   function automatic logic [8:0] pick_dim();
      case ($urandom_range(0, 7))
         0:       return 9'd2;
         1:       return 9'd3;
         2:       return 9'd256;
         3:       return 9'd0;      // clamps up to 2
         4:       return 9'd1;
         5:       return 9'd511;    // clamps down to 256
         6:       return 9'($urandom_range(257, 511));
         default: return 9'($urandom_range(2, 256));
      endcase
   endfunction

   function automatic logic [23:0] pick_scale();
      case ($urandom_range(0, 5))
         0:       return 24'd0;
         1:       return 24'hFFFFFF;
         2:       return 24'd255;
         3:       return 24'($urandom_range(0, 4095));
         default: return 24'($urandom);
      endcase
   endfunction

   // Directed opening: corner bytes at the extremes, both triangles and the
   // diagonal, negative coordinates, the right/top edge, dim clamping.
   task automatic directed_part();
      configure(9'd2, 24'hFFFFFF);
      send_load(16'd0, 8'd255);
      send_load(16'd1, 8'd0);
      send_load(16'd2, 8'd128);
      send_load(16'd3, 8'd255);
      send_query(24'h000000, 24'h000000);
      send_query(24'h0000FF, 24'h000000);    // lower-right triangle
      send_query(24'h000000, 24'h0000FF);    // upper-left triangle
      send_query(24'h000080, 24'h000080);    // on the diagonal
      send_query(24'h0000FF, 24'h0000FE);
      send_query(24'hFFFFFF, 24'h000000);    // x just below zero
      send_query(24'h000000, 24'h800000);    // most negative z
      send_query(24'h000100, 24'h000010);    // no right neighbour
      send_query(24'h000010, 24'h000100);    // no upper neighbour
      send_query(24'h7FFFFF, 24'h7FFFFF);
      configure(9'd0, 24'd255);
      send_query(24'h000040, 24'h0000C0);
      configure(9'd511, 24'd256);
      send_load(16'd256, 8'd255);
      send_load(16'd257, 8'd7);
      send_query(24'h000010, 24'h000020);
      load_cell(254, 254, 1'b0);
      send_query(24'h00FEFF, 24'h00FEFF);    // last cell, far corner
      send_query(24'h00FF00, 24'h000000);    // one past the last cell
   endtask

   task automatic random_segment(int n);
      int          first;
      int          roll;
      int unsigned d;
      int unsigned xi;
      int unsigned zi;
      int unsigned c;
      logic signed [23:0] x;
      logic signed [23:0] z;
      logic signed [23:0] t;
      first = items_sent;
      while (items_sent - first < n) begin
         d    = mirror.dim_used();
         roll = $urandom_range(0, 99);
         if (roll < 50) begin
            // fresh cell: four corner loads then a few queries into it
            xi = ($urandom_range(0, 3) == 0) ? d - 2 : $urandom_range(0, d - 2);
            zi = ($urandom_range(0, 3) == 0) ? d - 2 : $urandom_range(0, d - 2);
            load_cell(xi, zi, 1'b0);
            cells.insert(cells.size(), (zi << 16) | xi);
            repeat ($urandom_range(1, 3)) query_cell(xi, zi);
         end else if (roll < 70) begin
            if (cells.size() != 0) begin
               c = cells[$urandom_range(0, cells.size() - 1)];
               query_cell(c & 16'hFFFF, c >> 16);
            end
         end else if (roll < 82) begin
            // just past the right or top edge, or negative
            x = 24'((d - 1 + $urandom_range(0, 2)) * ONE + $urandom_range(0, 255));
            z = 24'($urandom_range(0, (d - 1) * ONE - 1));
            if ($urandom_range(0, 3) == 0) x = -24'($urandom_range(1, 8388608));
            if ($urandom_range(0, 1) == 0) begin
               t = x;
               x = z;
               z = t;
            end
            send_query(x, z);
         end else if (roll < 92) begin
            // any 24-bit position; prime the cell first if it lands inside
            x = 24'($urandom);
            z = 24'($urandom);
            if ($urandom_range(0, 1) == 0) x[23] = 1'b0;
            if ($urandom_range(0, 1) == 0) z[23] = 1'b0;
            if (x >= 0 && z >= 0 && x[23:8] + 1 < d && z[23:8] + 1 < d)
               if (!mirror.cell_ready(x[23:8], z[23:8]))
                  load_cell(x[23:8], z[23:8], 1'b1);
            send_query(x, z);
         end else begin
            send_load(16'($urandom), rand_height());
         end
      end
   endtask

   initial begin
      mirror = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 37;
      recv_idle_pct = 56;
      directed_part();

      // three idle mixes, four register settings in each
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 56 : 0;
         recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 37 : 0;
         for (int seg = 0; seg < 4; seg++) begin
            if (phase == 0 && seg == 0) configure(9'd256, 24'hFFFFFF);
            else if (phase == 0 && seg == 1) configure(9'd2, 24'd0);
            else configure(pick_dim(), pick_scale());
            random_segment(SEG_ITEMS);
         end
      end
      settle();

      $display("%0d requests: %0d loads, %0d queries (%0d inside the grid), %0d register writes",
               items_sent, mirror.loads, mirror.queries, mirror.hits, csr_writes);
      $display("idle mixes 37/56, 56/37 and none; %0d mismatches", mirror.errors);
      if (mirror.errors == 0)
         $display("heightmap_triangle_height_query_tb: done, clean");
      else
         $display("heightmap_triangle_height_query_tb: done, errors");
      $finish;
   end

endmodule

// ===== heightmap_triangle_height_query.f =====
sv/hmth_pkg.sv
sv/hmth_queue.sv
sv/hmth_front.sv
sv/hmth_back.sv
sv/heightmap_triangle_height_query.sv
tb/sv/heightmap_triangle_height_query_tb.sv
